@@ rtl/pffa_pkg.sv @@
// Shared widths, codes and reset values of the page fault frame allocator.
package pffa_pkg;

   // Field widths of the request, response and control register port.
   localparam int KIND_W        = 2;
   localparam int PAGE_W        = 6;
   localparam int TAG_W         = 8;
   localparam int STATUS_W      = 3;
   localparam int FRAME_OUT_W   = 5;
   localparam int DISK_W        = 16;
   localparam int PAGE_COUNT_W  = 7;
   localparam int FRAME_LIMIT_W = 6;
   localparam int CSR_DATA_W    = 7;
   localparam int CSR_INDEX_W   = 1;

   // Number of valid bits the victim search examines per cycle.
   localparam int SCAN_W = 8;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_FAULT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DIRTY = 2'd1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_FREE     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_REPLACED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_RESIDENT = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DIRTY    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED  = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_REPORT   = 3'd5;

   // Control register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_COUNT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LIMIT = 1'b1;

   // Control register values after reset.
   localparam logic [PAGE_COUNT_W-1:0]  PAGE_COUNT_RESET  = 7'd64;
   localparam logic [FRAME_LIMIT_W-1:0] FRAME_LIMIT_RESET = 6'd32;

   // Status of the victim search, handed from the scanner to the sequencer.
   typedef struct packed {
      logic done;
      logic found;
   } scan_status_type;

endpackage

@@ rtl/pffa_if.sv @@
// Request and response channel interfaces of the page fault frame allocator.
interface pffa_req_if;
   import pffa_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [PAGE_W-1:0]   page_index;
   logic [TAG_W-1:0]    requester;

   modport source (output valid, output kind, output page_index, output requester,
                   input ready);
   modport sink   (input valid, input kind, input page_index, input requester,
                   output ready);
endinterface

interface pffa_rsp_if;
   import pffa_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [TAG_W-1:0]       resume_tag;
   logic [FRAME_OUT_W-1:0] frame_number;
   logic [PAGE_W-1:0]      victim_page;
   logic                   victim_written;
   logic [DISK_W-1:0]      disk_accesses;

   modport source (output valid, output status, output resume_tag, output frame_number,
                   output victim_page, output victim_written, output disk_accesses,
                   input ready);
   modport sink   (input valid, input status, input resume_tag, input frame_number,
                   input victim_page, input victim_written, input disk_accesses,
                   output ready);
endinterface

@@ rtl/pffa_frame_ram.sv @@
// Frame number memory of the page table: one write port, one registered read port.
module pffa_frame_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 5
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pffa_victim_scan.sv @@
// Victim search: finds the lowest resident page, one group of valid bits per cycle.
module pffa_victim_scan #(
   parameter int MAX_PAGES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [MAX_PAGES-1:0]          page_valid,
   output pffa_pkg::scan_status_type     scan_status,
   output logic [$clog2(MAX_PAGES)-1:0]  victim_index
);
   import pffa_pkg::*;

   localparam int PAGE_AW    = $clog2(MAX_PAGES);
   localparam int NUM_GROUPS = (MAX_PAGES + SCAN_W - 1) / SCAN_W;
   localparam int GRP_AW     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int OFF_W      = $clog2(SCAN_W);
   localparam int PAD_W      = NUM_GROUPS * SCAN_W;

   localparam logic [GRP_AW-1:0] LAST_GROUP = GRP_AW'(NUM_GROUPS - 1);

   logic                busy_ff;
   logic                busy_in;
   logic [GRP_AW-1:0]   grp_ff;
   logic [GRP_AW-1:0]   grp_in;
   logic                done_ff;
   logic                done_in;
   logic                found_ff;
   logic                found_in;
   logic [PAGE_AW-1:0]  index_ff;
   logic [PAGE_AW-1:0]  index_in;

   logic [PAD_W-1:0]    padded;
   logic [SCAN_W-1:0]   slice;
   logic                hit;
   logic [OFF_W-1:0]    offset;

   assign padded = PAD_W'(page_valid);
   assign slice  = padded[grp_ff*SCAN_W +: SCAN_W];
   assign hit    = |slice;

   // Lowest set bit of the current group.
   always_comb begin
      offset = '0;
      for (int i = SCAN_W - 1; i >= 0; i--) begin
         if (slice[i]) begin
            offset = OFF_W'(i);
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      grp_in   = grp_ff;
      done_in  = 1'b0;
      found_in = found_ff;
      index_in = index_ff;
      if (start) begin
         busy_in = 1'b1;
         grp_in  = '0;
      end else if (busy_ff) begin
         if (hit || grp_ff == LAST_GROUP) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            found_in = hit;
            index_in = PAGE_AW'({grp_ff, offset});
         end else begin
            grp_in = grp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      grp_ff   <= grp_in;
      found_ff <= found_in;
      index_ff <= index_in;
   end

   assign scan_status.done  = done_ff;
   assign scan_status.found = found_ff;
   assign victim_index      = index_ff;

endmodule

@@ rtl/page_fault_frame_allocator_top.sv @@
// Top level of the page fault frame allocator: page table, sequencer and response register.
//
// The block keeps a page table (valid, frame and dirty per page), a resident count and a
// saturating 16-bit disk access counter. A fault for a page that is not resident takes the
// next free frame while fewer pages are resident than the frame limit, and otherwise evicts
// the lowest-index resident page and reuses its frame; a dirty victim counts one extra disk
// write. A fault for a resident page returns its frame unchanged. A dirty item marks a
// resident page, and a report item returns the counter. Every request gives one response.
// Items are handled one at a time and req_ch.ready is high only while the sequencer is idle.
// Report, dirty and free-frame items pass through decode and result; a resident page adds a
// frame memory read, and an eviction runs the victim scanner, which walks groups of eight
// valid bits until it meets the lowest resident page (at most ceil(MAX_PAGES / 8) groups),
// then an evict step. The sequencer goes back to idle while the response waits in its output
// register, so the next item is taken even if the previous response has not yet been
// collected. Control registers (index 0 page count, index 1 frame limit) are written through
// csr_we; the user must write them only while the block is idle, which the block does not
// enforce. There is no clearing pass after reset.
module page_fault_frame_allocator_top #(
   parameter int MAX_PAGES  = 64,
   parameter int MAX_FRAMES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   pffa_req_if.sink                          req_ch,
   pffa_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [pffa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pffa_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pffa_pkg::*;

   localparam int PAGE_AW = $clog2(MAX_PAGES);
   localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int RC_W    = $clog2(MAX_FRAMES + 1);
   localparam int PC_A    = $clog2(MAX_PAGES + 1);
   localparam int PC_W    = (PC_A > PAGE_COUNT_W) ? PC_A : PAGE_COUNT_W;
   localparam int FL_A    = $clog2(MAX_FRAMES + 1);
   localparam int FL_W    = (FL_A > FRAME_LIMIT_W) ? FL_A : FRAME_LIMIT_W;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_HIT    = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_EVICT  = 3'd4;
   localparam logic [2:0] ST_RESULT = 3'd5;

   // Control registers.
   logic [PAGE_COUNT_W-1:0]  page_count_ff;
   logic [FRAME_LIMIT_W-1:0] frame_limit_ff;

   // Page table state.
   logic [MAX_PAGES-1:0]     valid_ff;
   logic [MAX_PAGES-1:0]     valid_in;
   logic [MAX_PAGES-1:0]     dirty_ff;
   logic [MAX_PAGES-1:0]     dirty_in;
   logic [RC_W-1:0]          resident_ff;
   logic [RC_W-1:0]          resident_in;
   logic [DISK_W-1:0]        disk_ff;
   logic [DISK_W-1:0]        disk_in;

   // Sequencer and the item under work.
   logic [2:0]               state_ff;
   logic [2:0]               state_in;
   logic [KIND_W-1:0]        kind_ff;
   logic [PAGE_W-1:0]        pg_ff;
   logic [TAG_W-1:0]         tag_ff;
   logic [PAGE_AW-1:0]       victim_ff;
   logic [PAGE_AW-1:0]       victim_in;

   // Result being assembled.
   logic [STATUS_W-1:0]      res_status_ff;
   logic [STATUS_W-1:0]      res_status_in;
   logic [FRAME_W-1:0]       res_frame_ff;
   logic [FRAME_W-1:0]       res_frame_in;
   logic [PAGE_AW-1:0]       res_victim_ff;
   logic [PAGE_AW-1:0]       res_victim_in;
   logic                     res_written_ff;
   logic                     res_written_in;

   // Response output register.
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [TAG_W-1:0]         rsp_tag_ff;
   logic [FRAME_OUT_W-1:0]   rsp_frame_ff;
   logic [PAGE_W-1:0]        rsp_victim_ff;
   logic                     rsp_written_ff;
   logic [DISK_W-1:0]        rsp_disk_ff;
   logic                     rsp_load;

   // Derived values.
   logic                     req_fire;
   logic [PAGE_AW-1:0]       pg_idx;
   logic [PC_W-1:0]          pages_ext;
   logic [PC_W-1:0]          eff_pages;
   logic [FL_W-1:0]          limit_ext;
   logic [FL_W-1:0]          limit_cap;
   logic [FL_W-1:0]          eff_limit;
   logic                     in_range;
   logic                     pg_resident;
   logic                     has_free;
   logic [1:0]               disk_inc;
   logic [DISK_W:0]          disk_sum;

   // Frame memory and victim scanner connections.
   logic                     ram_we;
   logic [PAGE_AW-1:0]       ram_waddr;
   logic [FRAME_W-1:0]       ram_wdata;
   logic [PAGE_AW-1:0]       ram_raddr;
   logic [FRAME_W-1:0]       ram_rdata;
   logic                     scan_start;
   scan_status_type          scan_status;
   logic [PAGE_AW-1:0]       scan_index;

   pffa_frame_ram #(
      .DEPTH (MAX_PAGES),
      .WIDTH (FRAME_W)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   pffa_victim_scan #(
      .MAX_PAGES (MAX_PAGES)
   ) u_victim_scan (
      .clock        (clock),
      .reset        (reset),
      .start        (scan_start),
      .page_valid   (valid_ff),
      .scan_status  (scan_status),
      .victim_index (scan_index)
   );

   assign req_fire = req_ch.valid && req_ch.ready;
   assign pg_idx   = PAGE_AW'(pg_ff);

   // The page count is capped at the table size; zero means no page is in use.
   assign pages_ext = PC_W'(page_count_ff);
   assign eff_pages = (pages_ext > PC_W'(MAX_PAGES)) ? PC_W'(MAX_PAGES) : pages_ext;
   assign in_range  = PC_W'(pg_ff) < eff_pages;

   // The frame limit is capped at the frame count and never falls below one.
   assign limit_ext = FL_W'(frame_limit_ff);
   assign limit_cap = (limit_ext > FL_W'(MAX_FRAMES)) ? FL_W'(MAX_FRAMES) : limit_ext;
   assign eff_limit = (limit_cap == '0) ? FL_W'(1) : limit_cap;
   assign has_free  = FL_W'(resident_ff) < eff_limit;

   assign pg_resident = in_range && valid_ff[pg_idx];

   // Control register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff  <= PAGE_COUNT_RESET;
         frame_limit_ff <= FRAME_LIMIT_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_PAGE_COUNT) begin
            page_count_ff <= csr_wdata;
         end else if (csr_index == CSR_FRAME_LIMIT) begin
            frame_limit_ff <= csr_wdata[FRAME_LIMIT_W-1:0];
         end
      end
   end

   // Sequencer: decides the outcome of the held item and updates the page table.
   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      dirty_in       = dirty_ff;
      resident_in    = resident_ff;
      victim_in      = victim_ff;
      res_status_in  = res_status_ff;
      res_frame_in   = res_frame_ff;
      res_victim_in  = res_victim_ff;
      res_written_in = res_written_ff;
      disk_inc       = 2'd0;
      ram_we         = 1'b0;
      ram_waddr      = pg_idx;
      ram_wdata      = ram_rdata;
      ram_raddr      = pg_idx;
      scan_start     = 1'b0;
      rsp_load       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_status_in  = STATUS_IGNORED;
               res_frame_in   = '0;
               res_victim_in  = '0;
               res_written_in = 1'b0;
               state_in       = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_RESULT;
            case (kind_ff)
               KIND_FAULT: begin
                  if (pg_resident) begin
                     // Frame comes from the memory read started in this cycle.
                     res_status_in = STATUS_RESIDENT;
                     state_in      = ST_HIT;
                  end else if (in_range && has_free) begin
                     ram_we           = 1'b1;
                     ram_wdata        = FRAME_W'(resident_ff);
                     valid_in[pg_idx] = 1'b1;
                     dirty_in[pg_idx] = 1'b0;
                     resident_in      = resident_ff + 1'b1;
                     disk_inc         = 2'd1;
                     res_status_in    = STATUS_FREE;
                     res_frame_in     = FRAME_W'(resident_ff);
                  end else if (in_range) begin
                     scan_start = 1'b1;
                     state_in   = ST_SCAN;
                  end
               end
               KIND_DIRTY: begin
                  if (pg_resident) begin
                     dirty_in[pg_idx] = 1'b1;
                     res_status_in    = STATUS_DIRTY;
                  end
               end
               default: begin
                  res_status_in = STATUS_REPORT;
               end
            endcase
         end
         ST_HIT: begin
            res_frame_in = ram_rdata;
            state_in     = ST_RESULT;
         end
         ST_SCAN: begin
            ram_raddr = scan_index;
            if (scan_status.done) begin
               victim_in = scan_index;
               state_in  = scan_status.found ? ST_EVICT : ST_RESULT;
            end
         end
         ST_EVICT: begin
            // The victim's frame moves to the requested page.
            ram_we              = 1'b1;
            ram_wdata           = ram_rdata;
            valid_in[victim_ff] = 1'b0;
            dirty_in[victim_ff] = 1'b0;
            valid_in[pg_idx]    = 1'b1;
            dirty_in[pg_idx]    = 1'b0;
            disk_inc            = dirty_ff[victim_ff] ? 2'd2 : 2'd1;
            res_status_in       = STATUS_REPLACED;
            res_frame_in        = ram_rdata;
            res_victim_in       = victim_ff;
            res_written_in      = dirty_ff[victim_ff];
            state_in            = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Saturating disk access counter.
   assign disk_sum = {1'b0, disk_ff} + (DISK_W + 1)'(disk_inc);
   assign disk_in  = disk_sum[DISK_W] ? {DISK_W{1'b1}} : disk_sum[DISK_W-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         resident_ff  <= '0;
         disk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         resident_ff  <= resident_in;
         disk_ff      <= disk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         kind_ff <= req_ch.kind;
         pg_ff   <= req_ch.page_index;
         tag_ff  <= req_ch.requester;
      end
      victim_ff      <= victim_in;
      res_status_ff  <= res_status_in;
      res_frame_ff   <= res_frame_in;
      res_victim_ff  <= res_victim_in;
      res_written_ff <= res_written_in;
      if (rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_tag_ff     <= tag_ff;
         rsp_frame_ff   <= FRAME_OUT_W'(res_frame_ff);
         rsp_victim_ff  <= PAGE_W'(res_victim_ff);
         rsp_written_ff <= res_written_ff;
         rsp_disk_ff    <= disk_ff;
      end
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.resume_tag     = rsp_tag_ff;
   assign rsp_ch.frame_number   = rsp_frame_ff;
   assign rsp_ch.victim_page    = rsp_victim_ff;
   assign rsp_ch.victim_written = rsp_written_ff;
   assign rsp_ch.disk_accesses  = rsp_disk_ff;

   // An accepted item always moves the sequencer out of idle.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_DECODE)
      else $error("accepted item did not start decoding");

   // A result handed over by the sequencer is always offered as a response.
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("result handed over but response not offered");

   // The scanner only reports pages that are resident.
   a_scan_hits_valid: assert property (@(posedge clock) disable iff (reset)
      (scan_status.done && scan_status.found) |-> valid_ff[scan_index])
      else $error("victim search returned a page that is not resident");

   // The victim is never the page being loaded.
   a_victim_not_target: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVICT |-> victim_ff != pg_idx)
      else $error("victim equals the requested page");

   // Eviction swaps pages and leaves the resident count unchanged.
   a_evict_keeps_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVICT |=> $stable(resident_ff))
      else $error("resident count changed during eviction");

   // The disk access counter never goes backward.
   a_disk_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> disk_ff >= $past(disk_ff))
      else $error("disk access counter decreased");

endmodule
